// ----- hw/rtl/sard_pkg.sv -----
// Package for the slot allocator with reuse delay.
// Holds the sequencer state type, mode codes, register map and parameter defaults.
// No dependencies.
`default_nettype none

package sard_pkg;

    // parameter defaults
    localparam int SLOT_COUNT_DEF  = 8;
    localparam int DELAY_WIDTH_DEF = 16;

    // fixed field widths
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int GSLOT_W  = 3;
    localparam int CFG_W    = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // register map
    localparam logic [0:0] REG_REUSE_DELAY = 1'b0;
    localparam logic [CFG_W-1:0] REUSE_DELAY_RESET = 16'd1000;

    // item modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TICK
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/slot_allocator_with_reuse_delay.sv -----
// Slot allocator with reuse delay: top level, sequencer and slot state.
// Depends on sard_pkg.
`default_nettype none

// Usage
//   Command channel: an item (i_mode, i_slot_index) transfers at a rising edge
//   with start high and busy low. Modes: allocate, release, query, tick.
//   Result channel: o_done is high for exactly one cycle with o_granted,
//   o_granted_slot and o_slot_busy; the receiver cannot stall, so a result
//   is gone after that cycle.
//   Results and walks: release, query and an allocate whose start index
//   is outside the pool answer in the cycle after the transfer and do not
//   raise busy. An allocate from start index s walks one slot per cycle
//   through a single delay comparator, stopping at the first free slot with
//   no delay left, else granting the free slot with least delay left at the
//   pool's end; result in the cycle after the last slot looked at. A tick walks
//   all slots through one decrementer, result likewise. busy is high during walks.
//   Configuration: APB, register reuse_delay_ticks at byte address 0, pready
//   always high. The user writes it only while idle; not enforced by the block.
//   Reset (synchronous, active low): all slots free with no delay left,
//   reuse_delay_ticks = 1000, no result pending.

module slot_allocator_with_reuse_delay #(
    parameter int SLOT_COUNT  = sard_pkg::SLOT_COUNT_DEF,
    parameter int DELAY_WIDTH = sard_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // command channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [sard_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [sard_pkg::INDEX_W-1:0] i_slot_index,
    // result channel
    output logic                              o_done,
    output logic                              o_granted,
    output logic [sard_pkg::GSLOT_W-1:0]      o_granted_slot,
    output logic                              o_slot_busy,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sard_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sard_pkg::DATA_W-1:0]  pwdata,
    output logic [sard_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int PTR_W = $clog2(SLOT_COUNT);
    localparam logic [PTR_W-1:0] LastSlot = PTR_W'(SLOT_COUNT - 1);
    localparam logic [32:0] DelayMax = (33'd1 << DELAY_WIDTH) - 33'd1;

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    sard_pkg::t_state        r_state, n_state;
    logic [PTR_W-1:0]        r_ptr, n_ptr;          // walk pointer
    logic                    r_have, n_have;        // a delayed candidate seen
    logic [PTR_W-1:0]        r_best, n_best;        // candidate slot
    logic [DELAY_WIDTH-1:0]  r_best_d, n_best_d;    // candidate delay
    logic [sard_pkg::CFG_W-1:0] r_cfg;

    logic                    r_done, n_done;
    logic                    r_granted, n_granted;
    logic [PTR_W-1:0]        r_gslot, n_gslot;
    logic                    r_sbusy, n_sbusy;

    logic                    r_busy  [SLOT_COUNT];
    logic [DELAY_WIDTH-1:0]  r_delay [SLOT_COUNT];

    // array write controls from the sequencer
    logic                    w_set_busy;
    logic [PTR_W-1:0]        w_set_idx;
    logic                    w_release;
    logic                    w_dly_we;
    logic [PTR_W-1:0]        w_dly_idx;
    logic [DELAY_WIDTH-1:0]  w_dly_val;

    logic                    w_accept;
    logic                    w_in_range;
    logic [PTR_W-1:0]        w_idx;
    logic [DELAY_WIDTH-1:0]  w_reload;
    logic                    w_cfg_we;

    // shared slot unit: one delay read, zero test, compare and decrement
    logic [DELAY_WIDTH-1:0]  w_d;
    logic                    w_free;
    logic                    w_hit;
    logic                    w_better;
    logic                    w_last;

    logic [3:0]              w_gslot_ext;

    assign w_accept   = start && !busy;
    assign w_in_range = {1'b0, i_slot_index} < 5'(SLOT_COUNT);
    assign w_idx      = i_slot_index[PTR_W-1:0];

    // release reload saturates to the counter width
    assign w_reload = ({17'd0, r_cfg} > DelayMax) ? {DELAY_WIDTH{1'b1}}
                                                  : DELAY_WIDTH'(r_cfg);

    assign w_d      = r_delay[r_ptr];
    assign w_free   = !r_busy[r_ptr];
    assign w_hit    = w_free && (w_d == '0);
    assign w_better = w_free && (!r_have || (w_d < r_best_d));
    assign w_last   = (r_ptr == LastSlot);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_have     = r_have;
        n_best     = r_best;
        n_best_d   = r_best_d;
        n_done     = 1'b0;
        n_granted  = r_granted;
        n_gslot    = r_gslot;
        n_sbusy    = r_sbusy;
        w_set_busy = 1'b0;
        w_set_idx  = r_ptr;
        w_release  = 1'b0;
        w_dly_we   = 1'b0;
        w_dly_idx  = r_ptr;
        w_dly_val  = w_d;

        unique case (r_state)
            sard_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        sard_pkg::MODE_ALLOC: begin
                            if (w_in_range) begin
                                n_state = sard_pkg::ST_SCAN;
                                n_ptr   = w_idx;
                                n_have  = 1'b0;
                            end else begin
                                n_done    = 1'b1;
                                n_granted = 1'b0;
                                n_gslot   = '0;
                                n_sbusy   = 1'b0;
                            end
                        end
                        sard_pkg::MODE_RELEASE: begin
                            w_release = w_in_range;
                            w_dly_we  = w_in_range;
                            w_dly_idx = w_idx;
                            w_dly_val = w_reload;
                            n_done    = 1'b1;
                            n_granted = 1'b0;
                            n_gslot   = '0;
                            n_sbusy   = 1'b0;
                        end
                        sard_pkg::MODE_QUERY: begin
                            n_done    = 1'b1;
                            n_granted = 1'b0;
                            n_gslot   = '0;
                            n_sbusy   = w_in_range && r_busy[w_idx];
                        end
                        sard_pkg::MODE_TICK: begin
                            n_state = sard_pkg::ST_TICK;
                            n_ptr   = '0;
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end

            sard_pkg::ST_SCAN: begin
                n_sbusy = 1'b0;
                if (w_hit) begin
                    // free slot with delay run out: take it at once
                    w_set_busy = 1'b1;
                    w_set_idx  = r_ptr;
                    n_granted  = 1'b1;
                    n_gslot    = r_ptr;
                    n_done     = 1'b1;
                    n_state    = sard_pkg::ST_IDLE;
                end else begin
                    if (w_better) begin
                        n_have   = 1'b1;
                        n_best   = r_ptr;
                        n_best_d = w_d;
                    end
                    if (w_last) begin
                        // end of pool: fall back to the least delay left
                        w_set_busy = n_have;
                        w_set_idx  = n_best;
                        n_granted  = n_have;
                        n_gslot    = n_have ? n_best : '0;
                        n_done     = 1'b1;
                        n_state    = sard_pkg::ST_IDLE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end

            sard_pkg::ST_TICK: begin
                w_dly_we  = 1'b1;
                w_dly_idx = r_ptr;
                w_dly_val = w_d - DELAY_WIDTH'(w_d != '0);
                if (w_last) begin
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_gslot   = '0;
                    n_sbusy   = 1'b0;
                    n_state   = sard_pkg::ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            default: begin
                n_state = sard_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sard_pkg::ST_IDLE;
            r_have  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            r_done  <= n_done;
        end
    end

    // payload of the walk and the result
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_best    <= n_best;
        r_best_d  <= n_best_d;
        r_granted <= n_granted;
        r_gslot   <= n_gslot;
        r_sbusy   <= n_sbusy;
    end

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_busy[i]  <= 1'b0;
                r_delay[i] <= '0;
            end
        end else begin
            if (w_set_busy) begin
                r_busy[w_set_idx] <= 1'b1;
            end
            if (w_release) begin
                r_busy[w_idx] <= 1'b0;
            end
            if (w_dly_we) begin
                r_delay[w_dly_idx] <= w_dly_val;
            end
        end
    end

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign w_cfg_we = psel && penable && pwrite && pready
                      && (paddr[2] == sard_pkg::REG_REUSE_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sard_pkg::REUSE_DELAY_RESET;
        end else if (w_cfg_we) begin
            r_cfg <= pwdata[sard_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sard_pkg::REG_REUSE_DELAY)
                    ? sard_pkg::DATA_W'(r_cfg) : '0;

    // ---------------------------------------------------------------
    // outputs
    // ---------------------------------------------------------------
    assign w_gslot_ext    = 4'(r_gslot);
    assign busy           = (r_state != sard_pkg::ST_IDLE);
    assign o_done         = r_done;
    assign o_granted      = r_granted;
    assign o_granted_slot = w_gslot_ext[sard_pkg::GSLOT_W-1:0];
    assign o_slot_busy    = r_sbusy;

endmodule

`default_nettype wire

// ----- hw/rtl/sard_checker.sv -----
// Port-level checker for the slot allocator with reuse delay, with its bind.
// Depends on sard_pkg and binds to slot_allocator_with_reuse_delay.
`default_nettype none

module sard_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic [sard_pkg::MODE_W-1:0]  i_mode,
    input wire logic [sard_pkg::INDEX_W-1:0] i_slot_index,
    input wire logic                         o_done,
    input wire logic                         o_granted,
    input wire logic [sard_pkg::GSLOT_W-1:0] o_granted_slot,
    input wire logic                         o_slot_busy
);

    // a result never overlaps a walk in progress
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy))
        else $error("result strobe while busy");

    // every walk ends with a result
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("walk ended without a result");

    // a query answers in the next cycle
    a_query_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == sard_pkg::MODE_QUERY)) |=> (o_done && !o_granted))
        else $error("query result missing");

    // a failed or non-allocate result carries slot zero and no busy with a grant
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_granted || (o_granted_slot == '0)) && !(o_granted && o_slot_busy)))
        else $error("inconsistent result fields");

endmodule

bind slot_allocator_with_reuse_delay sard_checker u_sard_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for slot_allocator_with_reuse_delay: directed and random
// allocate/release/query/tick commands, with the reuse delay reprogrammed over APB.
// Depends on sard_pkg and the slot_allocator_with_reuse_delay RTL.

module testbench;
    import sard_pkg::*;

    localparam int SLOT_COUNT = SLOT_COUNT_DEF;
    localparam int DELAY_W    = DELAY_WIDTH_DEF;
    localparam longint unsigned DELAY_MAX = (64'd1 << DELAY_W) - 64'd1;
    localparam logic [ADDR_W-1:0] REUSE_DELAY_ADDR = ADDR_W'(4 * REG_REUSE_DELAY);

    // Longest quiet stretch we tolerate; it must cover a full tick walk plus the
    // longest sender gap plus an APB write and readback.
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int NUM_SETTINGS      = 8;
    localparam int ITEMS_PER_SETTING = 72;
    localparam int MAX_REPORTS       = 10;

    // One answer from the block, as the result ports carry it.
    typedef struct packed {
        logic               granted;
        logic [GSLOT_W-1:0] slot;
        logic               busy_bit;
    } t_answer;

    // Shadow copy of the slot pool. Each accepted command updates the copy and
    // queues the answer the block must give; each result pops and compares.
    class t_slot_pool_tracker;
        bit                 slot_taken [SLOT_COUNT];
        logic [DELAY_W-1:0] quarantine_left [SLOT_COUNT];
        logic [CFG_W-1:0]   reuse_delay;
        t_answer            expected_answers [$];
        int unsigned        mismatch_count;
        int unsigned        command_count;
        int unsigned        grant_count;
        int unsigned        refusal_count;
        int unsigned        busy_hits;

        function new();
            reuse_delay = REUSE_DELAY_RESET;
            foreach (slot_taken[i]) begin
                slot_taken[i]      = 1'b0;
                quarantine_left[i] = '0;
            end
            mismatch_count = 0;
            command_count  = 0;
            grant_count    = 0;
            refusal_count  = 0;
            busy_hits      = 0;
        endfunction

        function void note_mismatch(string what, longint unsigned want, longint unsigned got);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        endfunction

        // reload clamps to what the countdown can hold
        function logic [DELAY_W-1:0] reload_value();
            longint unsigned r;
            r = reuse_delay;
            if (r > DELAY_MAX)
                r = DELAY_MAX;
            return DELAY_W'(r);
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] index);
            t_answer            ans;
            bit                 found;
            bit                 have_old;
            int                 old_idx;
            logic [DELAY_W-1:0] old_delay;
            ans       = '0;
            found     = 1'b0;
            have_old  = 1'b0;
            old_idx   = 0;
            old_delay = '0;
            command_count++;
            case (mode)
                MODE_ALLOC: begin
                    // first free slot with no delay wins; else least delay left
                    for (int i = index; i < SLOT_COUNT; i++) begin
                        if (!found && !slot_taken[i]) begin
                            if (quarantine_left[i] == '0) begin
                                found    = 1'b1;
                                old_idx  = i;
                            end else if (!have_old || quarantine_left[i] < old_delay) begin
                                have_old  = 1'b1;
                                old_idx   = i;
                                old_delay = quarantine_left[i];
                            end
                        end
                    end
                    if (found || have_old) begin
                        slot_taken[old_idx] = 1'b1;
                        ans.granted = 1'b1;
                        ans.slot    = GSLOT_W'(old_idx);
                        grant_count++;
                    end else begin
                        refusal_count++;
                    end
                end
                MODE_RELEASE: begin
                    if (index < SLOT_COUNT) begin
                        slot_taken[index]      = 1'b0;
                        quarantine_left[index] = reload_value();
                    end
                end
                MODE_QUERY: begin
                    if (index < SLOT_COUNT)
                        ans.busy_bit = slot_taken[index];
                    if (ans.busy_bit)
                        busy_hits++;
                end
                default: begin
                    foreach (quarantine_left[i])
                        if (quarantine_left[i] != '0)
                            quarantine_left[i] = quarantine_left[i] - 1'b1;
                end
            endcase
            expected_answers = {expected_answers, ans};
        endfunction

        function void check_answer(logic granted, logic [GSLOT_W-1:0] slot, logic busy_bit);
            t_answer want;
            if (expected_answers.size() == 0) begin
                note_mismatch("result with nothing pending, granted", 0, granted);
                return;
            end
            want = expected_answers.pop_front();
            if (granted !== want.granted)
                note_mismatch("granted", want.granted, granted);
            if (slot !== want.slot)
                note_mismatch("granted_slot", want.slot, slot);
            if (busy_bit !== want.busy_bit)
                note_mismatch("slot_busy", want.busy_bit, busy_bit);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode;
    logic [INDEX_W-1:0]    i_slot_index;
    logic                  o_done;
    logic                  o_granted;
    logic [GSLOT_W-1:0]    o_granted_slot;
    logic                  o_slot_busy;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    t_slot_pool_tracker    pool;
    bit                    gaps_enabled;
    int                    quiet_cycles;
    logic [CFG_W-1:0]      delay_settings [NUM_SETTINGS];

    slot_allocator_with_reuse_delay dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_granted_slot (o_granted_slot),
        .o_slot_busy    (o_slot_busy),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor and watchdog. Everything is sampled at the rising edge, so the
    // values seen are the ones that were on the wires during the cycle just
    // ended; a command transfers when start was high and busy low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                pool.note_command(i_mode, i_slot_index);
            if (o_done)
                pool.check_answer(o_granted, o_granted_slot, o_slot_busy);
            if ((start && !busy) || o_done || (psel && penable)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: %0d cycles without a transfer", quiet_cycles);
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Holds start high until the command transfers. With gaps enabled it may
    // then drop start for a random gap with junk on the payload; without
    // a gap start stays high and the next call raises it again in the same step.
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic [INDEX_W-1:0] index);
        start        <= 1'b1;
        i_mode       <= mode;
        i_slot_index <= index;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (gaps_enabled && $urandom_range(3) == 0) begin
            start        <= 1'b0;
            i_mode       <= MODE_W'($urandom);
            i_slot_index <= INDEX_W'($urandom);
            repeat ($urandom_range(6, 1))
                @(posedge i_clk);
        end
    endtask

    // Drain: every queued answer seen and the scan/tick walk finished, then an
    // idle wait so nothing is still in flight.
    task automatic settle();
        start <= 1'b0;
        while (pool.expected_answers.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SLOT_COUNT + 2)
            @(posedge i_clk);
    endtask

    // APB write of reuse_delay_ticks (setup, access), then a readback.
    // Upper data bits are random; only the low CFG_W bits land in the register.
    task automatic program_reuse_delay(input logic [CFG_W-1:0] ticks);
        logic [DATA_W-1:0] word;
        word          = $urandom;
        word[CFG_W-1:0] = ticks;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REUSE_DELAY_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pool.reuse_delay = ticks;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== ticks)
            pool.note_mismatch("reuse_delay_ticks readback", ticks, prdata[CFG_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;
        int                 pick;

        start        <= 1'b0;
        i_mode       <= MODE_TICK;
        i_slot_index <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        quiet_cycles <= 0;
        gaps_enabled = 1'b1;
        pool = new();

        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset delay of 1000 ticks.
        send_command(MODE_TICK, 4'd0);      // nothing counting: stays at zero
        send_command(MODE_QUERY, 4'd0);
        send_command(MODE_ALLOC, 4'd15);    // start past the pool: refused without a scan
        send_command(MODE_ALLOC, 4'd7);     // last slot
        repeat (8)
            send_command(MODE_ALLOC, 4'd0); // fills 0..6, then pool exhausted
        send_command(MODE_QUERY, 4'd7);
        send_command(MODE_QUERY, 4'd15);    // out of range reads not busy
        send_command(MODE_RELEASE, 4'd15);  // out of range, ignored
        send_command(MODE_RELEASE, 4'd2);
        send_command(MODE_RELEASE, 4'd5);
        send_command(MODE_TICK, 4'd9);
        send_command(MODE_RELEASE, 4'd3);
        send_command(MODE_ALLOC, 4'd0);     // 2 and 5 tie on least delay: lower wins
        send_command(MODE_ALLOC, 4'd4);
        send_command(MODE_ALLOC, 4'd0);
        send_command(MODE_RELEASE, 4'd3);
        send_command(MODE_RELEASE, 4'd3);   // release of a slot already free
        send_command(MODE_QUERY, 4'd3);

        // Zero delay: a released slot is reusable at once.
        settle();
        program_reuse_delay(16'd0);
        send_command(MODE_RELEASE, 4'd1);
        send_command(MODE_ALLOC, 4'd1);

        // Largest delay: quarantined slots can only go by least delay left.
        settle();
        program_reuse_delay(16'hFFFF);
        send_command(MODE_RELEASE, 4'd6);
        send_command(MODE_TICK, 4'd0);
        send_command(MODE_ALLOC, 4'd6);

        // Random phases. Small delays let quarantine expire within a phase so
        // both grant paths show up; the last phase runs with no idling at all.
        delay_settings[0] = 16'd1;
        delay_settings[1] = 16'd3;
        delay_settings[2] = 16'd0;
        delay_settings[3] = 16'd2;
        delay_settings[4] = 16'hFFFF;
        delay_settings[5] = CFG_W'($urandom_range(12, 1));
        delay_settings[6] = CFG_W'($urandom);
        delay_settings[7] = 16'd5;
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            settle();
            program_reuse_delay(delay_settings[p]);
            gaps_enabled = (p != NUM_SETTINGS - 1);
            repeat (ITEMS_PER_SETTING) begin
                pick = $urandom_range(99);
                if (pick < 35)
                    mode = MODE_ALLOC;
                else if (pick < 60)
                    mode = MODE_RELEASE;
                else if (pick < 75)
                    mode = MODE_QUERY;
                else
                    mode = MODE_TICK;
                // mostly in the pool, now and then anywhere in the 4-bit range
                if ($urandom_range(9) == 0)
                    index = INDEX_W'($urandom_range(15));
                else if (mode == MODE_ALLOC)
                    index = INDEX_W'($urandom_range(SLOT_COUNT / 2));
                else
                    index = INDEX_W'($urandom_range(SLOT_COUNT - 1));
                send_command(mode, index);
            end
        end

        settle();
        $display("Ran %0d commands over %0d reuse-delay settings plus directed extremes:",
                 pool.command_count, NUM_SETTINGS);
        $display("  %0d grants, %0d refused allocates, %0d queries that found a slot busy",
                 pool.grant_count, pool.refusal_count, pool.busy_hits);
        if (pool.mismatch_count == 0 && pool.expected_answers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d answers never seen",
                     pool.mismatch_count, pool.expected_answers.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
